FILE: hdl/tbe_pkg.sv
// Shared types and constants for the two-color block encoder.
`timescale 1ns / 1ps
`default_nettype none
package tbe_pkg;

   localparam int ENTRY_W  = 28;   // {r5, g6, b5, alpha8, pos4}
   localparam int CDIST_W  = 32;
   localparam int ADIST_W  = 16;
   localparam int DENT_W   = CDIST_W + ADIST_W;
   localparam int CSUM_W   = 36;
   localparam int ASUM_W   = 20;

   localparam logic [1:0] FMT_DXT1 = 2'd0;
   localparam logic [1:0] FMT_DXT3 = 2'd1;
   localparam logic [1:0] FMT_DXT5 = 2'd2;

   localparam logic [1:0] METRIC_WEIGHTED = 2'd0;
   localparam logic [1:0] METRIC_SRGB     = 2'd1;
   localparam logic [1:0] METRIC_PLAIN    = 2'd2;
   localparam logic [1:0] METRIC_YUV      = 2'd3;

   localparam logic REG_FORMAT = 1'b0;
   localparam logic REG_METRIC = 1'b1;

   localparam logic [2:0] DRAIN_CYCLES = 3'd4;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] opacity;
      logic [1:0] column;
      logic [1:0] row;
      logic       last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [63:0] block_word;
      logic        last_word;
   } word_type;

   typedef struct packed {
      logic        push;
      logic        two;
      logic [63:0] word_a;
      logic [63:0] word_b;
   } emit_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_FILL,
      ST_FILL_DRAIN,
      ST_PAIR,
      ST_PAIR_DRAIN,
      ST_END_C,
      ST_END_A,
      ST_END_W,
      ST_CODE,
      ST_CODE_DRAIN,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

FILE: hdl/tbe_dist.sv
// Four-stage pipelined color and alpha distance unit.
`timescale 1ns / 1ps
`default_nettype none
module tbe_dist #(
   parameter int TAG_W = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [TAG_W-1:0]            in_tag,
   input  wire logic [15:0]                 color_a,
   input  wire logic [15:0]                 color_b,
   input  wire logic [7:0]                  alpha_a,
   input  wire logic [7:0]                  alpha_b,
   input  wire logic [1:0]                  metric,
   output logic                             out_valid,
   output logic [TAG_W-1:0]                 out_tag,
   output logic [tbe_pkg::CDIST_W-1:0]      out_cdist,
   output logic [tbe_pkg::ADIST_W-1:0]      out_adist
);

   // stage 1: channel differences, alpha min distance
   logic [4:0]  ar, br, ab5, bb5;
   logic [5:0]  ag, bg;
   logic [9:0]  ra2, rb2, ba2, bb2;
   logic [11:0] ga2, gb2;
   logic [13:0] dr_in, dg_in, db_in;
   logic [7:0]  ad, am_in;

   logic        s1_valid_ff;
   logic [TAG_W-1:0] s1_tag_ff;
   logic [13:0] s1_dr_ff, s1_dg_ff, s1_db_ff;
   logic [7:0]  s1_am_ff;
   logic [1:0]  s1_metric_ff;

   always_comb begin
      ar  = color_a[15:11];
      ag  = color_a[10:5];
      ab5 = color_a[4:0];
      br  = color_b[15:11];
      bg  = color_b[10:5];
      bb5 = color_b[4:0];
      ra2 = ar * ar;
      rb2 = br * br;
      ga2 = ag * ag;
      gb2 = bg * bg;
      ba2 = ab5 * ab5;
      bb2 = bb5 * bb5;
      if (metric == tbe_pkg::METRIC_SRGB) begin
         dr_in = {4'b0, ra2} - {4'b0, rb2};
         dg_in = {2'b0, ga2} - {2'b0, gb2};
         db_in = {4'b0, ba2} - {4'b0, bb2};
      end else begin
         dr_in = {9'b0, ar} - {9'b0, br};
         dg_in = {8'b0, ag} - {8'b0, bg};
         db_in = {9'b0, ab5} - {9'b0, bb5};
      end
      ad    = (alpha_a >= alpha_b) ? (alpha_a - alpha_b) : (alpha_b - alpha_a);
      am_in = ad;
      if (alpha_b < am_in) am_in = alpha_b;
      if ((8'd255 - alpha_b) < am_in) am_in = 8'd255 - alpha_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_tag_ff    <= in_tag;
      s1_dr_ff     <= dr_in;
      s1_dg_ff     <= dg_in;
      s1_db_ff     <= db_in;
      s1_am_ff     <= am_in;
      s1_metric_ff <= metric;
   end

   // stage 2: luma / chroma terms and multiplier operands
   logic signed [23:0] er, eg, eb, y, u, v;
   logic signed [23:0] p1a_in, p1b_in, p2a_in, p2b_in, p3a_in, p3b_in;

   logic        s2_valid_ff;
   logic [TAG_W-1:0] s2_tag_ff;
   logic signed [23:0] s2_p1a_ff, s2_p1b_ff, s2_p2a_ff, s2_p2b_ff, s2_p3a_ff, s2_p3b_ff;
   logic [7:0]  s2_am_ff;
   logic [1:0]  s2_metric_ff;

   always_comb begin
      er = {{10{s1_dr_ff[13]}}, s1_dr_ff};
      eg = {{10{s1_dg_ff[13]}}, s1_dg_ff};
      eb = {{10{s1_db_ff[13]}}, s1_db_ff};
      y  = '0;
      u  = '0;
      v  = '0;
      p1a_in = er; p1b_in = er;
      p2a_in = eg; p2b_in = eg;
      p3a_in = eb; p3b_in = eb;
      case (s1_metric_ff)
         tbe_pkg::METRIC_SRGB: begin
            y = er * 24'sd84 + eg * 24'sd72 + eb * 24'sd28;
            u = er * 24'sd409 - y;
            v = eb * 24'sd409 - y;
            p1a_in = (y + 24'sd4) >>> 3;
            p1b_in = (y + 24'sd8) >>> 4;
            p2a_in = (u + 24'sd4) >>> 3;
            p2b_in = (u + 24'sd8) >>> 4;
            p3a_in = (v + 24'sd4) >>> 3;
            p3b_in = (v + 24'sd8) >>> 4;
         end
         tbe_pkg::METRIC_PLAIN: begin
            y = '0;
         end
         tbe_pkg::METRIC_YUV: begin
            y = er * 24'sd60 + eg * 24'sd59 + eb * 24'sd22;
            u = er * 24'sd202 - y;
            v = eb * 24'sd202 - y;
            p1a_in = y; p1b_in = y;
            p2a_in = u; p2b_in = u;
            p3a_in = v; p3b_in = v;
         end
         default: begin
            y = er * 24'sd42 + eg * 24'sd72 + eb * 24'sd14;
            u = er * 24'sd202 - y;
            v = eb * 24'sd202 - y;
            p1a_in = y; p1b_in = y;
            p2a_in = u; p2b_in = u;
            p3a_in = v; p3b_in = v;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_tag_ff    <= s1_tag_ff;
      s2_p1a_ff    <= p1a_in;
      s2_p1b_ff    <= p1b_in;
      s2_p2a_ff    <= p2a_in;
      s2_p2b_ff    <= p2b_in;
      s2_p3a_ff    <= p3a_in;
      s2_p3b_ff    <= p3b_in;
      s2_am_ff     <= s1_am_ff;
      s2_metric_ff <= s1_metric_ff;
   end

   // stage 3: products
   logic        s3_valid_ff;
   logic [TAG_W-1:0] s3_tag_ff;
   logic signed [47:0] s3_q1_ff, s3_q2_ff, s3_q3_ff;
   logic [15:0] s3_ad_ff;
   logic [1:0]  s3_metric_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_tag_ff    <= s2_tag_ff;
      s3_q1_ff     <= s2_p1a_ff * s2_p1b_ff;
      s3_q2_ff     <= s2_p2a_ff * s2_p2b_ff;
      s3_q3_ff     <= s2_p3a_ff * s2_p3b_ff;
      s3_ad_ff     <= s2_am_ff * s2_am_ff;
      s3_metric_ff <= s2_metric_ff;
   end

   // stage 4: weighted sum
   logic signed [47:0] total;

   always_comb begin
      case (s3_metric_ff)
         tbe_pkg::METRIC_PLAIN: total = s3_q1_ff + s3_q2_ff + s3_q3_ff;
         tbe_pkg::METRIC_SRGB:  total = ((s3_q1_ff + 48'sd8) >>> 4)
                                      + ((s3_q2_ff + 48'sd128) >>> 8)
                                      + ((s3_q3_ff + 48'sd256) >>> 9);
         default:               total = (s3_q1_ff <<< 1)
                                      + ((s3_q2_ff + 48'sd4) >>> 3)
                                      + ((s3_q3_ff + 48'sd8) >>> 4);
      endcase
   end

   logic        s4_valid_ff;
   logic [TAG_W-1:0] s4_tag_ff;
   logic [tbe_pkg::CDIST_W-1:0] s4_cd_ff;
   logic [tbe_pkg::ADIST_W-1:0] s4_ad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_tag_ff <= s3_tag_ff;
      s4_cd_ff  <= total[tbe_pkg::CDIST_W-1:0];
      s4_ad_ff  <= s3_ad_ff;
   end

   assign out_valid = s4_valid_ff;
   assign out_tag   = s4_tag_ff;
   assign out_cdist = s4_cd_ff;
   assign out_adist = s4_ad_ff;

endmodule
`default_nettype wire

FILE: hdl/tbe_core.sv
// Pixel store, distance table and encode sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tbe_core #(
   parameter int MAX_PIXELS = 16,
   parameter int IDX_W      = 4,
   parameter int CNT_W      = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pix_valid,
   input  wire tbe_pkg::pixel_type  pix,
   output logic                     ready,
   input  wire logic [1:0]          fmt,
   input  wire logic [1:0]          metric,
   input  wire logic                out_free,
   output tbe_pkg::emit_type        emit
);

   localparam int TAG_W = 2 * IDX_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

   // memories
   logic [tbe_pkg::ENTRY_W-1:0] pmem [MAX_PIXELS];
   logic [tbe_pkg::DENT_W-1:0]  dmem [2**TAG_W];

   logic                        pm_we;
   logic [IDX_W-1:0]            pm_waddr, pa_addr, pb_addr;
   logic [tbe_pkg::ENTRY_W-1:0] pm_wdata, pa_q_ff, pb_q_ff;
   logic [TAG_W-1:0]            da_addr, db_addr;
   logic [tbe_pkg::DENT_W-1:0]  da_q_ff, db_q_ff;

   logic                        dist_ov;
   logic [TAG_W-1:0]            dist_otag;
   logic [tbe_pkg::CDIST_W-1:0] dist_cd;
   logic [tbe_pkg::ADIST_W-1:0] dist_ad;

   always_ff @(posedge clock) begin
      if (pm_we) pmem[pm_waddr] <= pm_wdata;
      pa_q_ff <= pmem[pa_addr];
      pb_q_ff <= pmem[pb_addr];
   end

   always_ff @(posedge clock) begin
      if (dist_ov) dmem[dist_otag] <= {dist_cd, dist_ad};
      da_q_ff <= dmem[da_addr];
      db_q_ff <= dmem[db_addr];
   end

   // control registers
   tbe_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in, n_ff, n_in;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic               fill_v_ff, fill_v_in, pair_v_ff, pair_v_in, code_v_ff, code_v_in;
   logic               last_ff, last_in;
   logic [TAG_W-1:0]   tagd_ff, tagd_in;
   logic [IDX_W-1:0]   di_ff, di_in, dj_ff, dj_in;
   logic [2:0]         drain_ff, drain_in;
   logic [tbe_pkg::CSUM_W-1:0] csum_ff, csum_in, cbest_ff, cbest_in;
   logic [tbe_pkg::ASUM_W-1:0] asum_ff, asum_in, abest_ff, abest_in;
   logic               best_ok_ff, best_ok_in;
   logic [IDX_W-1:0]   bi_ff, bi_in, bj_ff, bj_in, ai_ff, ai_in, aj_ff, aj_in;
   logic [IDX_W-1:0]   e0_ff, e0_in, e1_ff, e1_in;
   logic [15:0]        c0_ff, c0_in, c1_ff, c1_in;
   logic [7:0]         a0_ff, a0_in, a1_ff, a1_in;
   logic [31:0]        idx_ff, idx_in;
   logic [63:0]        aword_ff, aword_in;

   logic [1:0]       fmt_eff;
   logic [CNT_W-1:0] nm1, nm2;
   logic             i_last, j_last, k_last, store_full;

   assign fmt_eff = (fmt == tbe_pkg::FMT_DXT3 || fmt == tbe_pkg::FMT_DXT5) ? fmt
                                                                           : tbe_pkg::FMT_DXT1;
   assign nm1        = n_ff - CNT_W'(1);
   assign nm2        = n_ff - CNT_W'(2);
   assign i_last     = ({1'b0, i_ff} == nm1);
   assign j_last     = ({1'b0, j_ff} == nm1);
   assign k_last     = ({1'b0, k_ff} == nm1);
   assign store_full = (count_ff == MAX_CNT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbe_pkg::ST_LOAD:
            if (pix_valid && pix.last_pixel) state_in = tbe_pkg::ST_FILL;
         tbe_pkg::ST_FILL:
            if (i_last && k_last) state_in = tbe_pkg::ST_FILL_DRAIN;
         tbe_pkg::ST_FILL_DRAIN:
            if (drain_ff == 3'd0)
               state_in = (n_ff >= CNT_W'(2)) ? tbe_pkg::ST_PAIR : tbe_pkg::ST_END_C;
         tbe_pkg::ST_PAIR:
            if ({1'b0, i_ff} == nm2 && j_last && k_last) state_in = tbe_pkg::ST_PAIR_DRAIN;
         tbe_pkg::ST_PAIR_DRAIN: state_in = tbe_pkg::ST_END_C;
         tbe_pkg::ST_END_C:      state_in = tbe_pkg::ST_END_A;
         tbe_pkg::ST_END_A:      state_in = tbe_pkg::ST_END_W;
         tbe_pkg::ST_END_W:      state_in = tbe_pkg::ST_CODE;
         tbe_pkg::ST_CODE:
            if (k_last) state_in = tbe_pkg::ST_CODE_DRAIN;
         tbe_pkg::ST_CODE_DRAIN: state_in = tbe_pkg::ST_EMIT;
         tbe_pkg::ST_EMIT:
            if (out_free) state_in = tbe_pkg::ST_LOAD;
         default:                state_in = tbe_pkg::ST_LOAD;
      endcase
   end

   // datapath and outputs
   logic [CNT_W-1:0]           cnt_new;
   logic [tbe_pkg::CDIST_W-1:0] cmin, cd0, cd1;
   logic [tbe_pkg::ADIST_W-1:0] amin;
   logic [tbe_pkg::CSUM_W-1:0] csum_nx;
   logic [tbe_pkg::ASUM_W-1:0] asum_nx;
   logic [15:0]                ca, cb;
   logic [7:0]                 ak, ea0, ea1, eaf, pa_al, pb_al;
   logic [3:0]                 pos;
   logic                       far0;
   logic [2:0]                 acode;
   logic [5:0]                 pos3;
   logic [63:0]                color_word;

   always_comb begin
      ready      = (state_ff == tbe_pkg::ST_LOAD);
      pm_we      = 1'b0;
      pm_waddr   = count_ff[IDX_W-1:0];
      pm_wdata   = {pix.red[7:3], pix.green[7:2], pix.blue[7:3], pix.opacity,
                    pix.row, pix.column};
      pa_addr    = i_ff;
      pb_addr    = k_ff;
      da_addr    = {i_ff, k_ff};
      db_addr    = {j_ff, k_ff};
      count_in   = count_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      fill_v_in  = 1'b0;
      pair_v_in  = 1'b0;
      code_v_in  = 1'b0;
      last_in    = k_last;
      tagd_in    = {i_ff, k_ff};
      di_in      = i_ff;
      dj_in      = j_ff;
      drain_in   = drain_ff;
      csum_in    = csum_ff;
      asum_in    = asum_ff;
      cbest_in   = cbest_ff;
      abest_in   = abest_ff;
      best_ok_in = best_ok_ff;
      bi_in      = bi_ff;
      bj_in      = bj_ff;
      ai_in      = ai_ff;
      aj_in      = aj_ff;
      e0_in      = e0_ff;
      e1_in      = e1_ff;
      c0_in      = c0_ff;
      c1_in      = c1_ff;
      a0_in      = a0_ff;
      a1_in      = a1_ff;
      idx_in     = idx_ff;
      aword_in   = aword_ff;
      cnt_new    = count_ff + CNT_W'(1);
      ca         = pa_q_ff[27:12];
      cb         = pb_q_ff[27:12];
      pa_al      = pa_q_ff[11:4];
      pb_al      = pb_q_ff[11:4];

      case (state_ff)
         tbe_pkg::ST_LOAD: begin
            if (pix_valid) begin
               pm_we = !store_full;
               if (!store_full) count_in = cnt_new;
               if (pix.last_pixel) begin
                  n_in       = store_full ? count_ff : cnt_new;
                  count_in   = '0;
                  i_in       = '0;
                  j_in       = '0;
                  k_in       = '0;
                  best_ok_in = 1'b0;
                  bi_in      = '0;
                  bj_in      = '0;
                  ai_in      = '0;
                  aj_in      = '0;
                  csum_in    = '0;
                  asum_in    = '0;
                  idx_in     = '0;
                  aword_in   = '0;
               end
            end
         end
         tbe_pkg::ST_FILL: begin
            fill_v_in = 1'b1;
            drain_in  = tbe_pkg::DRAIN_CYCLES;
            k_in      = k_ff + IDX_W'(1);
            if (k_last) begin
               k_in = '0;
               i_in = i_ff + IDX_W'(1);
            end
         end
         tbe_pkg::ST_FILL_DRAIN: begin
            drain_in = drain_ff - 3'd1;
            i_in     = '0;
            j_in     = IDX_W'(1);
            k_in     = '0;
         end
         tbe_pkg::ST_PAIR: begin
            pair_v_in = 1'b1;
            k_in      = k_ff + IDX_W'(1);
            if (k_last) begin
               k_in = '0;
               if (j_last) begin
                  i_in = i_ff + IDX_W'(1);
                  j_in = i_ff + IDX_W'(2);
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end
         end
         tbe_pkg::ST_END_C: begin
            pa_addr = bi_ff;
            pb_addr = bj_ff;
         end
         tbe_pkg::ST_END_A: begin
            ca      = pa_q_ff[27:12];
            cb      = pb_q_ff[27:12];
            pa_addr = ai_ff;
            pb_addr = aj_ff;
            if (ca < cb) begin
               c0_in = cb; c1_in = ca; e0_in = bj_ff; e1_in = bi_ff;
            end else begin
               c0_in = ca; c1_in = cb; e0_in = bi_ff; e1_in = bj_ff;
            end
         end
         tbe_pkg::ST_END_W: begin
            pa_al = pa_q_ff[11:4];
            pb_al = pb_q_ff[11:4];
            a0_in = (pb_al < pa_al) ? pb_al : pa_al;
            a1_in = (pb_al < pa_al) ? pa_al : pb_al;
            if (fmt_eff == tbe_pkg::FMT_DXT5) aword_in = {48'b0, a1_in, a0_in};
            k_in  = '0;
         end
         tbe_pkg::ST_CODE: begin
            code_v_in = 1'b1;
            da_addr   = {e0_ff, k_ff};
            db_addr   = {e1_ff, k_ff};
            pa_addr   = k_ff;
            k_in      = k_ff + IDX_W'(1);
         end
         default: begin
         end
      endcase

      // pair accumulation, one distance-table pair per cycle
      cmin    = (da_q_ff[47:16] < db_q_ff[47:16]) ? da_q_ff[47:16] : db_q_ff[47:16];
      amin    = (da_q_ff[15:0] < db_q_ff[15:0]) ? da_q_ff[15:0] : db_q_ff[15:0];
      csum_nx = csum_ff + tbe_pkg::CSUM_W'(cmin);
      asum_nx = asum_ff + tbe_pkg::ASUM_W'(amin);
      if (pair_v_ff) begin
         csum_in = csum_nx;
         asum_in = asum_nx;
         if (last_ff) begin
            csum_in    = '0;
            asum_in    = '0;
            best_ok_in = 1'b1;
            if (!best_ok_ff || csum_nx < cbest_ff) begin
               cbest_in = csum_nx; bi_in = di_ff; bj_in = dj_ff;
            end
            if (!best_ok_ff || asum_nx < abest_ff) begin
               abest_in = asum_nx; ai_in = di_ff; aj_in = dj_ff;
            end
         end
      end

      // per-pixel codes
      cd0   = da_q_ff[47:16];
      cd1   = db_q_ff[47:16];
      far0  = cd0 > cd1;
      ak    = pa_q_ff[11:4];
      pos   = pa_q_ff[3:0];
      ea0   = (a0_ff >= ak) ? (a0_ff - ak) : (ak - a0_ff);
      ea1   = (a1_ff >= ak) ? (a1_ff - ak) : (ak - a1_ff);
      eaf   = 8'd255 - ak;
      if (ak <= ea0 && ak <= ea1 && ak <= eaf) acode = 3'd6;
      else if (eaf <= ea0 && eaf <= ea1)       acode = 3'd7;
      else if (ea0 <= ea1)                     acode = 3'd0;
      else                                     acode = 3'd1;
      pos3  = {1'b0, pos, 1'b0} + {2'b0, pos};
      if (code_v_ff) begin
         if (fmt_eff == tbe_pkg::FMT_DXT1) begin
            if (ak == 8'd0)  idx_in = idx_ff | (32'd3 << {pos, 1'b0});
            else if (far0)   idx_in = idx_ff | (32'd1 << {pos, 1'b0});
         end else begin
            if (far0) idx_in = idx_ff | (32'd1 << {pos, 1'b0});
            if (fmt_eff == tbe_pkg::FMT_DXT3)
               aword_in = aword_ff | (64'(ak[7:4]) << {pos, 2'b00});
            else
               aword_in = aword_ff | (64'(acode) << (7'd16 + {1'b0, pos3}));
         end
      end

      color_word  = {idx_ff, c1_ff, c0_ff};
      emit.push   = (state_ff == tbe_pkg::ST_EMIT) && out_free;
      emit.two    = (fmt_eff != tbe_pkg::FMT_DXT1);
      emit.word_a = emit.two ? aword_ff : color_word;
      emit.word_b = color_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tbe_pkg::ST_LOAD;
         count_ff  <= '0;
         fill_v_ff <= 1'b0;
         pair_v_ff <= 1'b0;
         code_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         fill_v_ff <= fill_v_in;
         pair_v_ff <= pair_v_in;
         code_v_ff <= code_v_in;
      end
      n_ff       <= n_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      last_ff    <= last_in;
      tagd_ff    <= tagd_in;
      di_ff      <= di_in;
      dj_ff      <= dj_in;
      drain_ff   <= drain_in;
      csum_ff    <= csum_in;
      asum_ff    <= asum_in;
      cbest_ff   <= cbest_in;
      abest_ff   <= abest_in;
      best_ok_ff <= best_ok_in;
      bi_ff      <= bi_in;
      bj_ff      <= bj_in;
      ai_ff      <= ai_in;
      aj_ff      <= aj_in;
      e0_ff      <= e0_in;
      e1_ff      <= e1_in;
      c0_ff      <= c0_in;
      c1_ff      <= c1_in;
      a0_ff      <= a0_in;
      a1_ff      <= a1_in;
      idx_ff     <= idx_in;
      aword_ff   <= aword_in;
   end

   tbe_dist #(
      .TAG_W (TAG_W)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fill_v_ff),
      .in_tag    (tagd_ff),
      .color_a   (pa_q_ff[27:12]),
      .color_b   (pb_q_ff[27:12]),
      .alpha_a   (pa_q_ff[11:4]),
      .alpha_b   (pb_q_ff[11:4]),
      .metric    (metric),
      .out_valid (dist_ov),
      .out_tag   (dist_otag),
      .out_cdist (dist_cd),
      .out_adist (dist_ad)
   );

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      emit.push |-> out_free) else $error("push into occupied output buffer");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("pixel count beyond store depth");
   a_table_write: assert property (@(posedge clock) disable iff (reset)
      dist_ov |-> (state_ff == tbe_pkg::ST_FILL || state_ff == tbe_pkg::ST_FILL_DRAIN))
      else $error("distance table written outside fill");
   a_pair_n: assert property (@(posedge clock) disable iff (reset)
      pair_v_ff |-> (n_ff >= CNT_W'(2))) else $error("pair search with fewer than two pixels");

endmodule
`default_nettype wire

FILE: hdl/texture_block_two_color_encoder_unit.sv
// Top level: two-color DXT block encoder with register port and output buffer.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel  direction  handshake              payload
//  req_*    in         req_valid / req_stall  pixel_type (RGBA, column, row, last_pixel)
//  rsp_*    out        rsp_valid / rsp_stall  word_type (block_word, last_word)
//  csr_*    in/out     APB write/read         block_format @0x0, distance_metric @0x4
//
//  Pixels are taken one per cycle while collecting. After the last pixel of a block,
//  the encoder fills the distance table, then searches for the endpoint pair, fed one
//  pair of table entries per cycle, then picks the endpoints, codes each pixel and emits.
//  Reset is synchronous and clears control state only; the stores need no clearing.
//  req_stall is high while a block encodes. A two-word output buffer lets the next
//  block's pixels come in while results wait on rsp_stall.
//
module texture_block_two_color_encoder_unit #(
   parameter int MAX_PIXELS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire tbe_pkg::pixel_type  req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output tbe_pkg::word_type        rsp_data,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [2:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int IDX_W = $clog2(MAX_PIXELS);
   localparam int CNT_W = IDX_W + 1;

   // configuration registers
   logic [1:0] fmt_ff, metric_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == tbe_pkg::REG_METRIC) ? {30'b0, metric_ff}
                                                            : {30'b0, fmt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= tbe_pkg::FMT_DXT1;
         metric_ff <= tbe_pkg::METRIC_WEIGHTED;
      end else if (csr_wr) begin
         if (csr_paddr[2] == tbe_pkg::REG_FORMAT) fmt_ff    <= csr_pwdata[1:0];
         else                                     metric_ff <= csr_pwdata[1:0];
      end
   end

   // encoder
   logic              core_ready, out_free, pix_accept;
   tbe_pkg::emit_type emit;

   assign req_stall  = !core_ready;
   assign pix_accept = req_valid && core_ready;

   tbe_core #(
      .MAX_PIXELS (MAX_PIXELS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_accept),
      .pix       (req_data),
      .ready     (core_ready),
      .fmt       (fmt_ff),
      .metric    (metric_ff),
      .out_free  (out_free),
      .emit      (emit)
   );

   // two-word output buffer; head drives the result channel
   tbe_pkg::word_type ob0_ff, ob0_in, ob1_ff, ob1_in;
   logic [1:0]        obcnt_ff, obcnt_in;
   logic              pop;

   assign out_free  = (obcnt_ff == 2'd0);
   assign rsp_valid = (obcnt_ff != 2'd0);
   assign rsp_data  = ob0_ff;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      ob0_in   = ob0_ff;
      ob1_in   = ob1_ff;
      obcnt_in = obcnt_ff;
      if (pop) begin
         ob0_in   = ob1_ff;
         obcnt_in = obcnt_ff - 2'd1;
      end
      if (emit.push) begin
         ob0_in.block_word = emit.word_a;
         ob0_in.last_word  = !emit.two;
         ob1_in.block_word = emit.word_b;
         ob1_in.last_word  = 1'b1;
         obcnt_in          = emit.two ? 2'd2 : 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obcnt_ff <= 2'd0;
      end else begin
         obcnt_ff <= obcnt_in;
      end
      ob0_ff <= ob0_in;
      ob1_ff <= ob1_in;
   end

endmodule
`default_nettype wire

FILE: verif/texture_block_two_color_encoder_unit_tb.sv
// Testbench for the two-color DXT block encoder: directed and random blocks, all settings.
`timescale 1ns / 1ps
`default_nettype none
module texture_block_two_color_encoder_unit_tb;

   localparam int  HALF_PERIOD = 6;
   localparam int  STORE_DEPTH = 16;
   localparam int  STALL_PCT   = 28;
   // Worst case: full-block encode plus long rsp stalls.
   localparam int  WATCHDOG_LIMIT = 40000;
   localparam logic [2:0] ADDR_FORMAT = {tbe_pkg::REG_FORMAT, 2'b00};
   localparam logic [2:0] ADDR_METRIC = {tbe_pkg::REG_METRIC, 2'b00};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   tbe_pkg::pixel_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   tbe_pkg::word_type  rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   texture_block_two_color_encoder_unit #(.MAX_PIXELS(STORE_DEPTH)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------
   // Encoder shadow: stored pixels and configuration
   // ---------------------------------------------------------------
   logic [4:0] sh_red [STORE_DEPTH];   // 5 bits used
   logic [5:0] sh_green [STORE_DEPTH];
   logic [4:0] sh_blue [STORE_DEPTH];
   logic [7:0] sh_alpha [STORE_DEPTH];
   logic [3:0] sh_pos [STORE_DEPTH];
   int         sh_count = 0;
   logic [1:0] cur_format = tbe_pkg::FMT_DXT1;
   logic [1:0] cur_metric = tbe_pkg::METRIC_WEIGHTED;

   tbe_pkg::word_type words_due[$];     // encoded words not yet seen on rsp
   int         mismatches = 0;
   int         pixels_sent = 0;
   int         blocks_sent = 0;
   int         words_seen = 0;
   bit         quiet = 1'b0;     // no-idle stretch on both sides

   function automatic longint rshift(longint x, int n);
      // add half, then floor (arithmetic shift floors)
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint rgb_err(int ar, int ag, int ab, int br, int bg, int bb);
      longint dr, dg, db, y, u, v;
      dr = ar - br;
      dg = ag - bg;
      db = ab - bb;
      case (cur_metric)
         tbe_pkg::METRIC_SRGB: begin
            dr = longint'(ar) * ar - longint'(br) * br;
            dg = longint'(ag) * ag - longint'(bg) * bg;
            db = longint'(ab) * ab - longint'(bb) * bb;
            y = dr * 84 + dg * 72 + db * 28;
            u = dr * 409 - y;
            v = db * 409 - y;
            return rshift(rshift(y, 3) * rshift(y, 4), 4)
                 + rshift(rshift(u, 3) * rshift(u, 4), 8)
                 + rshift(rshift(v, 3) * rshift(v, 4), 9);
         end
         tbe_pkg::METRIC_PLAIN: return dr * dr + dg * dg + db * db;
         tbe_pkg::METRIC_YUV:   y = dr * 60 + dg * 59 + db * 22;
         default:               y = dr * 42 + dg * 72 + db * 14;
      endcase
      u = dr * 202 - y;
      v = db * 202 - y;
      return 2 * y * y + rshift(u * u, 3) + rshift(v * v, 4);
   endfunction

   function automatic longint opacity_err(int a, int b);
      return longint'(a - b) * (a - b);
   endfunction

   function automatic logic [15:0] rgb565(int r, int g, int b);
      return {r[4:0], g[5:0], b[4:0]};
   endfunction

   // Encode the stored block and queue its words.
   function automatic void encode_block();
      int n, bi, bj, ai, aj, a0, a1, t, k, i, j;
      int c0[3], c1[3];
      logic [1:0] fmt;
      longint dtab[STORE_DEPTH][STORE_DEPTH];
      longint best, total, m, e0, e1, ez, ef;
      logic [63:0] alpha_word, codes, color_word;
      logic [2:0]  acode;
      tbe_pkg::word_type w;
      n = sh_count;
      fmt = (cur_format == tbe_pkg::FMT_DXT3 || cur_format == tbe_pkg::FMT_DXT5)
            ? cur_format : tbe_pkg::FMT_DXT1;
      bi = 0; bj = 0; ai = 0; aj = 0;
      alpha_word = '0; codes = '0;
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++)
            dtab[i][j] = rgb_err(sh_red[i], sh_green[i], sh_blue[i],
                                 sh_red[j], sh_green[j], sh_blue[j]);
      // endpoint pair: least summed nearest distance, first pair wins ties
      best = -1;
      for (i = 0; i < n; i++)
         for (j = i + 1; j < n; j++) begin
            total = 0;
            for (k = 0; k < n; k++)
               total += (dtab[i][k] < dtab[j][k]) ? dtab[i][k] : dtab[j][k];
            if (best < 0 || total < best) begin
               best = total; bi = i; bj = j;
            end
         end
      c0[0] = sh_red[bi]; c0[1] = sh_green[bi]; c0[2] = sh_blue[bi];
      c1[0] = sh_red[bj]; c1[1] = sh_green[bj]; c1[2] = sh_blue[bj];
      a0 = 0; a1 = 0;
      if (fmt == tbe_pkg::FMT_DXT5) begin
         best = -1;
         for (i = 0; i < n; i++)
            for (j = i + 1; j < n; j++) begin
               total = 0;
               for (k = 0; k < n; k++) begin
                  e0 = opacity_err(sh_alpha[i], sh_alpha[k]);
                  e1 = opacity_err(sh_alpha[j], sh_alpha[k]);
                  m = (e0 < e1) ? e0 : e1;
                  ez = opacity_err(0, sh_alpha[k]);
                  ef = opacity_err(255, sh_alpha[k]);
                  if (ez < m) m = ez;
                  if (ef < m) m = ef;
                  total += m;
               end
               if (best < 0 || total < best) begin
                  best = total; ai = i; aj = j;
               end
            end
         if (n < 2) aj = ai;
         a0 = sh_alpha[ai];
         a1 = sh_alpha[aj];
         if (a1 < a0) begin
            t = a0; a0 = a1; a1 = t;
         end
         alpha_word = {48'd0, a1[7:0], a0[7:0]};
      end
      if (rgb565(c0[0], c0[1], c0[2]) < rgb565(c1[0], c1[1], c1[2])) begin
         for (k = 0; k < 3; k++) begin
            t = c0[k]; c0[k] = c1[k]; c1[k] = t;
         end
      end
      for (k = 0; k < n; k++) begin
         bit far0;
         far0 = rgb_err(c0[0], c0[1], c0[2], sh_red[k], sh_green[k], sh_blue[k])
              > rgb_err(c1[0], c1[1], c1[2], sh_red[k], sh_green[k], sh_blue[k]);
         if (fmt == tbe_pkg::FMT_DXT1) begin
            if (sh_alpha[k] == 8'd0)
               codes |= 64'd3 << (sh_pos[k] * 2);   // transparent
            else if (far0)
               codes |= 64'd1 << (sh_pos[k] * 2);
         end else begin
            if (far0)
               codes |= 64'd1 << (sh_pos[k] * 2);
            if (fmt == tbe_pkg::FMT_DXT3) begin
               alpha_word |= 64'(sh_alpha[k][7:4]) << (sh_pos[k] * 4);
            end else begin
               e0 = opacity_err(a0, sh_alpha[k]);
               e1 = opacity_err(a1, sh_alpha[k]);
               ez = opacity_err(0, sh_alpha[k]);
               ef = opacity_err(255, sh_alpha[k]);
               if (ez <= e0 && ez <= e1 && ez <= ef) acode = 3'd6;
               else if (ef <= e0 && ef <= e1)        acode = 3'd7;
               else if (e0 <= e1)                     acode = 3'd0;
               else                                   acode = 3'd1;
               alpha_word |= 64'(acode) << (16 + sh_pos[k] * 3);
            end
         end
      end
      color_word = {codes[31:0], rgb565(c1[0], c1[1], c1[2]), rgb565(c0[0], c0[1], c0[2])};
      sh_count = 0;
      if (fmt != tbe_pkg::FMT_DXT1) begin
         w.block_word = alpha_word;
         w.last_word = 1'b0;
         words_due.push_back(w);
      end
      w.block_word = color_word;
      w.last_word = 1'b1;
      words_due.push_back(w);
   endfunction

   // Store an accepted pixel; a full store drops it, but last_pixel still ends the block.
   function automatic void take_pixel(tbe_pkg::pixel_type px);
      if (sh_count < STORE_DEPTH) begin
         sh_red[sh_count]   = px.red[7:3];
         sh_green[sh_count] = px.green[7:2];
         sh_blue[sh_count]  = px.blue[7:3];
         sh_alpha[sh_count] = px.opacity;
         sh_pos[sh_count]   = {px.row, px.column};
         sh_count++;
      end
      if (px.last_pixel) begin
         encode_block();
         blocks_sent++;
      end
   endfunction

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   // One pixel transaction; random idle gaps ahead of it unless in a quiet stretch.
   task automatic send_pixel(tbe_pkg::pixel_type px);
      while (!quiet && $urandom_range(99) < STALL_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = px;
      do @(posedge clock); while (req_stall);
      take_pixel(px);
      pixels_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (words_due.size() != 0) @(negedge clock);
      // encoder may still be finishing the output buffer
      repeat (4 * tbe_pkg::DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_paddr = addr; csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_FORMAT) cur_format = value[1:0];
      else                     cur_metric = value[1:0];
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
   endtask

   task automatic set_mode(logic [1:0] fmt, logic [1:0] metric);
      wait_drained();
      csr_write(ADDR_FORMAT, {30'd0, fmt});
      csr_write(ADDR_METRIC, {30'd0, metric});
   endtask

   function automatic logic [7:0] rand_channel();
      // lean on the extremes now and then
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // One block of n transactions; column-major order or scattered positions.
   task automatic send_block(int n, bit scatter);
      tbe_pkg::pixel_type px;
      for (int k = 0; k < n; k++) begin
         px.red = rand_channel();
         px.green = rand_channel();
         px.blue = rand_channel();
         px.opacity = rand_channel();
         if (scatter) begin
            px.column = 2'($urandom_range(3));
            px.row = 2'($urandom_range(3));
         end else begin
            px.column = 2'((k / 4) % 4);
            px.row = 2'(k % 4);
         end
         px.last_pixel = (k == n - 1);
         send_pixel(px);
      end
   endtask

   function automatic int rand_block_size();
      // mostly small blocks, a few full or overfull
      int r;
      r = $urandom_range(99);
      if (r < 8)  return $urandom_range(16, 19);
      if (r < 15) return 1;
      return $urandom_range(2, 8);
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      tbe_pkg::pixel_type px;
      set_mode(tbe_pkg::FMT_DXT1, tbe_pkg::METRIC_WEIGHTED);
      // single pixel, all ones
      px = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 2'd3, 1'b1};
      send_pixel(px);
      // two extremes plus a transparent pixel at a repeated position
      px = '{8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 2'd0, 1'b0};
      send_pixel(px);
      px = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 2'd0, 2'd0, 1'b0};
      send_pixel(px);
      px = '{8'h00, 8'hFF, 8'h00, 8'h80, 2'd2, 2'd1, 1'b1};
      send_pixel(px);
      set_mode(tbe_pkg::FMT_DXT3, tbe_pkg::METRIC_SRGB);
      px = '{8'h37, 8'hC8, 8'h0F, 8'hF0, 2'd1, 2'd2, 1'b0};
      send_pixel(px);
      px = '{8'hFF, 8'hFF, 8'hFF, 8'h0F, 2'd3, 2'd0, 1'b1};
      send_pixel(px);
      set_mode(tbe_pkg::FMT_DXT5, tbe_pkg::METRIC_PLAIN);
      px = '{8'h40, 8'h80, 8'hC0, 8'h7F, 2'd1, 2'd1, 1'b1};
      send_pixel(px);   // single pixel, both alpha endpoints equal
      px = '{8'h00, 8'h00, 8'h00, 8'h01, 2'd2, 2'd2, 1'b0};
      send_pixel(px);
      px = '{8'hFF, 8'hFF, 8'hFF, 8'hFE, 2'd3, 2'd1, 1'b1};
      send_pixel(px);
      // unused format code, encodes as DXT1
      set_mode(2'd3, tbe_pkg::METRIC_YUV);
      send_block(3, 1'b1);
      // overfull block: the 17th pixel is dropped but still ends the block
      set_mode(tbe_pkg::FMT_DXT1, tbe_pkg::METRIC_YUV);
      send_block(17, 1'b0);
   endtask

   task automatic test_random(int budget);
      int per_phase, done;
      per_phase = budget / 16;
      for (int f = 0; f < 4; f++)
         for (int m = 0; m < 4; m++) begin
            set_mode(2'(f), 2'(m));
            quiet = (f == 1 && m == 2);   // one long stretch with no idling
            done = 0;
            while (done < per_phase) begin
               int n;
               n = rand_block_size();
               send_block(n, $urandom_range(3) == 0);
               done += n;
               // hold off until every pending word is out, once per phase
               if (done >= per_phase / 2 && done - n < per_phase / 2)
                  wait_drained();
            end
            quiet = 1'b0;
         end
   endtask

   // ---------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------
   always @(negedge clock)
      rsp_stall <= !reset && !quiet && ($urandom_range(99) < STALL_PCT);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (words_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word %h last %b", $time,
                     rsp_data.block_word, rsp_data.last_word);
         end else begin
            tbe_pkg::word_type w;
            w = words_due.pop_front();
            if (w.block_word !== rsp_data.block_word) begin
               mismatches++;
               $display("%0t: block_word expected %h actual %h", $time,
                        w.block_word, rsp_data.block_word);
            end
            if (w.last_word !== rsp_data.last_word) begin
               mismatches++;
               $display("%0t: last_word expected %b actual %b", $time,
                        w.last_word, rsp_data.last_word);
            end
         end
      end
   end

   // Watchdog on cycles with no transaction anywhere
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d words outstanding", $time, words_due.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(1950);
      wait_drained();
      repeat (20) @(negedge clock);
      $display("covered %0d pixels in %0d blocks, %0d words, all formats and metrics",
               pixels_sent, blocks_sent, words_seen);
      $display("including overfull, single-pixel, repeated-position and transparent blocks");
      if (mismatches == 0 && words_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
hdl/tbe_pkg.sv
hdl/tbe_dist.sv
hdl/tbe_core.sv
hdl/texture_block_two_color_encoder_unit.sv
verif/texture_block_two_color_encoder_unit_tb.sv
